>>> sv/sha1md_pkg.sv
// shared types, constants and the control struct of the sha-1 digest engine
`default_nettype none

package sha1md_pkg;

   typedef logic [31:0]      word_type;
   typedef logic [4:0][31:0] chain_type;

   // round constants, one per group of twenty rounds
   localparam word_type K_R0 = 32'h5A827999;
   localparam word_type K_R1 = 32'h6ED9EBA1;
   localparam word_type K_R2 = 32'h8F1BBCDC;
   localparam word_type K_R3 = 32'hCA62C1D6;

   // initial chaining words, H0 in the low slot
   localparam chain_type CHAIN_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                       32'hEFCDAB89, 32'h67452301};

   localparam logic [6:0] ROUND_GRP1  = 7'd20;
   localparam logic [6:0] ROUND_GRP2  = 7'd40;
   localparam logic [6:0] ROUND_GRP3  = 7'd60;
   localparam logic [6:0] ROUND_LAST  = 7'd79;
   localparam logic [6:0] SCHED_WORDS = 7'd16;

   localparam logic [5:0] POS_LAST   = 6'd63;
   localparam logic [5:0] POS_LENGTH = 6'd56;   // length field starts at bit 448
   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;
   localparam logic [63:0] BITS_PER_BYTE = 64'd8;

   localparam logic [2:0] WORD_FIRST = 3'd0;
   localparam logic [2:0] WORD_LAST  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD_ONE,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_EMIT
   } state_type;

   // commands from the sequencer to the block line and the round unit
   typedef struct packed {
      logic       push;       // shift one byte into the block line
      logic [7:0] push_byte;
      logic       init;       // load the initial chaining words
      logic       start;      // copy chaining words into the working registers
      logic       step;       // run one round
      logic       fold;       // add working registers into the chaining words
      logic [6:0] rnd;        // current round number
   } core_ctrl_type;

endpackage

`default_nettype wire

>>> sv/sha1md_sched.sv
// 64-byte block line that collects bytes and rolls as the message schedule
`default_nettype none

module sha1md_sched
   import sha1md_pkg::*;
(
   input  wire logic          clock,
   input  wire core_ctrl_type ctrl,
   output word_type           sched_word
);

   // word 0 sits in the top 32 bits, oldest first
   logic [511:0] line_ff;
   logic [511:0] line_in;
   word_type     w0, w2, w8, w13, mix;

   assign w0  = line_ff[511 -: 32];
   assign w2  = line_ff[447 -: 32];
   assign w8  = line_ff[255 -: 32];
   assign w13 = line_ff[95  -: 32];
   assign mix = w13 ^ w8 ^ w2 ^ w0;

   assign sched_word = (ctrl.rnd < SCHED_WORDS) ? w0 : {mix[30:0], mix[31]};

   always_comb begin
      line_in = line_ff;
      if (ctrl.push) begin
         line_in = {line_ff[503:0], ctrl.push_byte};
      end else if (ctrl.step) begin
         line_in = {line_ff[479:0], sched_word};
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
   end

endmodule

`default_nettype wire

>>> sv/sha1md_round.sv
// shared round unit: working registers a..e and the five chaining words
`default_nettype none

module sha1md_round
   import sha1md_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire core_ctrl_type ctrl,
   input  wire word_type      sched_word,
   output chain_type          chain
);

   chain_type chain_ff, chain_in;
   word_type  a_ff, b_ff, c_ff, d_ff, e_ff;
   word_type  a_in, b_in, c_in, d_in, e_in;
   word_type  f_val, k_val, sum;

   // round function and constant for the current group of twenty
   always_comb begin
      if (ctrl.rnd < ROUND_GRP1) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K_R0;
      end else if (ctrl.rnd < ROUND_GRP2) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_R1;
      end else if (ctrl.rnd < ROUND_GRP3) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K_R2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K_R3;
      end
   end

   assign sum = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + sched_word + k_val;

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      chain_in = chain_ff;
      if (ctrl.start) begin
         a_in = chain_ff[0];
         b_in = chain_ff[1];
         c_in = chain_ff[2];
         d_in = chain_ff[3];
         e_in = chain_ff[4];
      end else if (ctrl.step) begin
         a_in = sum;
         b_in = a_ff;
         c_in = {b_ff[1:0], b_ff[31:2]};
         d_in = c_ff;
         e_in = d_ff;
      end
      if (ctrl.init) begin
         chain_in = CHAIN_INIT;
      end else if (ctrl.fold) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      if (reset) begin
         chain_ff <= CHAIN_INIT;
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign chain = chain_ff;

endmodule

`default_nettype wire

>>> sv/sha1_message_digest_top.sv
// sha-1 digest engine: byte request channel in, five digest words out
// usage
//   each request on req_* carries one message byte (req_byte_valid high) and/or
//   an end flag (req_is_last). a request with neither changes nothing. a request
//   with only req_is_last closes the message received so far, which may be empty.
//   on the end flag the block pads the message (0x80, zeros, 64-bit bit length),
//   then returns H0..H4 on rsp_* as five words, word_index 0..4, final_word on
//   the fifth, and starts over with fresh chaining words and a zero bit count.
// flow
//   a byte that does not complete a 64-byte block leaves the block idle; a byte that
//   completes one starts a compression (a load, rounds 0 to 79 through the single
//   round adder, a fold into the chaining words), and req_ready is low meanwhile.
//   closing a message pushes padding bytes one per cycle (up to 72), pausing while
//   a full block is compressed, and runs one or two more compressions.
// reset
//   synchronous, active high: back to idle with initial chaining words and an
//   empty message; block line contents are left as they are.
// stalls
//   each digest word holds on rsp_* until rsp_ready takes it; no new request is
//   taken until all five words have gone out.
`default_nettype none

module sha1_message_digest_top
   import sha1md_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_msg_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_is_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_final_word
);

   state_type     state_ff, state_in;
   state_type     ret_ff, ret_in;       // where to go after a compression
   logic [5:0]    pos_ff, pos_in;       // fill level of the block line
   logic [63:0]   bits_ff, bits_in;     // message length in bits, wraps
   logic [6:0]    rnd_ff, rnd_in;
   logic [2:0]    idx_ff, idx_in;
   core_ctrl_type ctrl;
   word_type      sched_word;
   chain_type     chain;
   logic [7:0]    len_byte;

   // big-endian length byte for the current slot of the length field
   assign len_byte = bits_ff[{~pos_ff[2:0], 3'b000} +: 8];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         pos_ff   <= '0;
         bits_ff  <= '0;
         rnd_ff   <= '0;
         idx_ff   <= WORD_FIRST;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pos_ff   <= pos_in;
         bits_ff  <= bits_in;
         rnd_ff   <= rnd_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      ret_in         = ret_ff;
      pos_in         = pos_ff;
      bits_in        = bits_ff;
      rnd_in         = rnd_ff;
      idx_in         = idx_ff;
      ctrl           = '0;
      ctrl.rnd       = rnd_ff;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_byte_valid) begin
                  ctrl.push      = 1'b1;
                  ctrl.push_byte = req_msg_byte;
                  pos_in         = pos_ff + 6'd1;
                  bits_in        = bits_ff + BITS_PER_BYTE;
                  if (pos_ff == POS_LAST) begin
                     // block full: compress, then resume
                     ctrl.start = 1'b1;
                     rnd_in     = '0;
                     state_in   = ST_ROUND;
                     ret_in     = req_is_last ? ST_PAD_ONE : ST_IDLE;
                  end else if (req_is_last) begin
                     state_in = ST_PAD_ONE;
                  end
               end else if (req_is_last) begin
                  state_in = ST_PAD_ONE;
               end
            end
         end
         ST_ROUND: begin
            ctrl.step = 1'b1;
            rnd_in    = rnd_ff + 7'd1;
            if (rnd_ff == ROUND_LAST) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            ctrl.fold = 1'b1;
            state_in  = ret_ff;
         end
         ST_PAD_ONE: begin
            ctrl.push      = 1'b1;
            ctrl.push_byte = PAD_BYTE;
            pos_in         = pos_ff + 6'd1;
            state_in       = ST_PAD_ZERO;
            if (pos_ff == POS_LAST) begin
               ctrl.start = 1'b1;
               rnd_in     = '0;
               state_in   = ST_ROUND;
               ret_in     = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (pos_ff == POS_LENGTH) begin
               state_in = ST_PAD_LEN;
            end else begin
               ctrl.push      = 1'b1;
               ctrl.push_byte = ZERO_BYTE;
               pos_in         = pos_ff + 6'd1;
               if (pos_ff == POS_LAST) begin
                  ctrl.start = 1'b1;
                  rnd_in     = '0;
                  state_in   = ST_ROUND;
                  ret_in     = ST_PAD_ZERO;
               end
            end
         end
         ST_PAD_LEN: begin
            ctrl.push      = 1'b1;
            ctrl.push_byte = len_byte;
            pos_in         = pos_ff + 6'd1;
            if (pos_ff == POS_LAST) begin
               ctrl.start = 1'b1;
               rnd_in     = '0;
               state_in   = ST_ROUND;
               ret_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (idx_ff == WORD_LAST) begin
                  // digest delivered: fresh message
                  idx_in    = WORD_FIRST;
                  ctrl.init = 1'b1;
                  bits_in   = '0;
                  state_in  = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   sha1md_sched u_sched (
      .clock      (clock),
      .ctrl       (ctrl),
      .sched_word (sched_word)
   );

   sha1md_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sched_word (sched_word),
      .chain      (chain)
   );

   assign rsp_digest_word = chain[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_final_word  = (idx_ff == WORD_LAST);

endmodule

`default_nettype wire

>>> sv/sha1md_check.sv
// port-level checker for the sha-1 digest engine and its bind
`default_nettype none

module sha1md_check
   import sha1md_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_is_last,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_word_index,
   input wire logic       rsp_final_word
);

   // no request taken while digest words are pending
   a_no_req_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while digest pending");

   // final flag marks exactly the last word
   a_final_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_final_word == (rsp_word_index == WORD_LAST)))
      else $error("final flag and word index disagree");

   // words follow back to back in order
   a_next_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_final_word)
         |=> (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word sequence broken");

   // after the fifth word the channel goes quiet
   a_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_final_word) |=> !rsp_valid)
      else $error("result after final word");

   // a request without the end flag never starts a digest
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_is_last) |=> !rsp_valid)
      else $error("digest without end of message");

endmodule

bind sha1_message_digest_top sha1md_check u_sha1md_check (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_is_last    (req_is_last),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_word_index (rsp_word_index),
   .rsp_final_word (rsp_final_word)
);

`default_nettype wire
